// File: hdl/pbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the PackBits monochrome bitmap decoder.
// No dependencies; imported by every module of the block.
package pbd_pkg;

   // Row limit applied to the height register
   localparam logic [12:0] MAX_ROWS = 13'd4096;
   // Longest run a single packet can announce
   localparam int unsigned MAX_RUN = 129;

   // Configuration register indexes
   localparam logic [1:0] CSR_COMPRESSED_MODE = 2'd0;
   localparam logic [1:0] CSR_WIDTH_PIXELS    = 2'd1;
   localparam logic [1:0] CSR_HEIGHT_ROWS     = 2'd2;

   // One decoded word travelling from the front end to the back end
   typedef struct packed {
      logic [7:0]  pixel_byte;
      logic [7:0]  repeat_count;
      logic [11:0] row_number;
      logic        row_end;
   } pbd_word_type;

   // Queue status seen by the front end and the back end
   typedef struct packed {
      logic full;
      logic empty;
   } pbd_queue_status_type;

endpackage
`default_nettype wire

// File: hdl/pbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts stream bytes, runs the row/packet phase machine and
// pushes one decoded word per data byte. Depends on pbd_pkg.
module pbd_front
   import pbd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [12:0]  csr_wdata,
   output logic              restart,
   input  wire pbd_queue_status_type q_status,
   output logic              push_valid,
   output pbd_word_type      push_word
);

   localparam logic [1:0] PH_ROWLEN  = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_LITERAL = 2'd2;
   localparam logic [1:0] PH_RUNVAL  = 2'd3;

   logic        compressed_mode_ff;
   logic [12:0] width_pixels_ff;
   logic [12:0] height_rows_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  row_length_ff, row_length_in;
   logic [15:0] row_consumed_ff, row_consumed_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic [7:0]  run_length_ff, run_length_in;
   logic [12:0] current_row_ff, current_row_in;

   logic        accept;
   logic        active;
   logic [12:0] row_limit;
   logic [13:0] width_round;
   logic [10:0] stride;
   logic [15:0] consumed_inc;
   logic [7:0]  literal_dec;
   logic [8:0]  run_calc;
   logic        word_end;

   assign restart   = csr_write && (csr_index == CSR_COMPRESSED_MODE
                                    || csr_index == CSR_WIDTH_PIXELS
                                    || csr_index == CSR_HEIGHT_ROWS);
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign row_limit    = (height_rows_ff > MAX_ROWS) ? MAX_ROWS : height_rows_ff;
   assign active       = current_row_ff < row_limit;
   assign width_round  = {1'b0, width_pixels_ff} + 14'd15;
   assign stride       = {width_round[13:4], 1'b0};
   assign consumed_inc = row_consumed_ff + 16'd1;
   assign literal_dec  = literal_left_ff - 8'd1;
   assign run_calc     = 9'd257 - {1'b0, req_data_byte};

   always_comb begin
      phase_in        = phase_ff;
      row_length_in   = row_length_ff;
      row_consumed_in = row_consumed_ff;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      current_row_in  = current_row_ff;
      push_valid      = 1'b0;
      word_end        = 1'b0;
      push_word.pixel_byte   = req_data_byte;
      push_word.repeat_count = 8'd1;
      push_word.row_number   = current_row_ff[11:0];
      if (accept && active) begin
         if (!compressed_mode_ff) begin
            if (stride != 11'd0) begin
               push_valid = 1'b1;
               word_end   = consumed_inc >= {5'd0, stride};
               if (word_end) begin
                  row_consumed_in = 16'd0;
                  current_row_in  = current_row_ff + 13'd1;
                  phase_in        = PH_ROWLEN;
               end else begin
                  row_consumed_in = consumed_inc;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_ROWLEN: begin
                  row_length_in   = req_data_byte;
                  row_consumed_in = 16'd0;
                  if (req_data_byte == 8'd0) begin
                     current_row_in = current_row_ff + 13'd1;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
               PH_HEADER: begin
                  row_consumed_in = consumed_inc;
                  if (!req_data_byte[7]) begin
                     literal_left_in = req_data_byte + 8'd1;
                     phase_in        = PH_LITERAL;
                  end else begin
                     run_length_in = run_calc[7:0];
                     phase_in      = PH_RUNVAL;
                  end
               end
               PH_LITERAL: begin
                  row_consumed_in = consumed_inc;
                  literal_left_in = literal_dec;
                  push_valid      = 1'b1;
                  word_end        = (literal_dec == 8'd0)
                                    && (consumed_inc >= {8'd0, row_length_ff});
                  if (literal_dec == 8'd0) begin
                     if (word_end) begin
                        current_row_in = current_row_ff + 13'd1;
                        phase_in       = PH_ROWLEN;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
               PH_RUNVAL: begin
                  row_consumed_in        = consumed_inc;
                  push_valid             = 1'b1;
                  push_word.repeat_count = run_length_ff;
                  word_end               = consumed_inc >= {8'd0, row_length_ff};
                  if (word_end) begin
                     current_row_in = current_row_ff + 13'd1;
                     phase_in       = PH_ROWLEN;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
               default: begin
                  phase_in = PH_ROWLEN;
               end
            endcase
         end
      end
      push_word.row_end = word_end;
   end

   // Configuration registers: take the listed reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         compressed_mode_ff <= 1'b1;
         width_pixels_ff    <= 13'd1;
         height_rows_ff     <= 13'd1;
      end else if (csr_write) begin
         if (csr_index == CSR_COMPRESSED_MODE) begin
            compressed_mode_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_WIDTH_PIXELS) begin
            width_pixels_ff <= csr_wdata;
         end
         if (csr_index == CSR_HEIGHT_ROWS) begin
            height_rows_ff <= csr_wdata;
         end
      end
   end

   // Decode state: restart on reset or on any valid register write
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff        <= PH_ROWLEN;
         row_length_ff   <= 8'd0;
         row_consumed_ff <= 16'd0;
         literal_left_ff <= 8'd0;
         run_length_ff   <= 8'd0;
         current_row_ff  <= 13'd0;
      end else begin
         phase_ff        <= phase_in;
         row_length_ff   <= row_length_in;
         row_consumed_ff <= row_consumed_in;
         literal_left_ff <= literal_left_in;
         run_length_ff   <= run_length_in;
         current_row_ff  <= current_row_in;
      end
   end

   // The row counter never runs past the row limit
   assert property (@(posedge clock) disable iff (reset)
      current_row_ff <= row_limit)
      else $error("row counter beyond row limit");

   // A word that closes a row steps the row counter
   assert property (@(posedge clock) disable iff (reset || restart)
      (push_valid && push_word.row_end) |=> current_row_ff == $past(current_row_ff) + 13'd1)
      else $error("row end without row advance");

endmodule
`default_nettype wire

// File: hdl/pbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry word queue between the front end and the back end.
// Depends on pbd_pkg for the word type.
module pbd_queue
   import pbd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire pbd_word_type  push_word,
   input  wire logic          pop,
   output pbd_word_type       pop_word,
   output pbd_queue_status_type status
);

   pbd_word_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push;
   logic         do_pop;

   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_word     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   // Occupancy stays within the two entries
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue occupancy overflow");

   // No push is ever offered while the queue is full
   assert property (@(posedge clock) disable iff (reset)
      !(push_valid && status.full))
      else $error("push into full queue");

endmodule
`default_nettype wire

// File: hdl/pbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: pops words, tracks the byte position within the row and holds
// the result register. Depends on pbd_pkg.
module pbd_back
   import pbd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          restart,
   input  wire pbd_queue_status_type q_status,
   input  wire pbd_word_type  pop_word,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_pixel_byte,
   output logic [7:0]         rsp_repeat_count,
   output logic [11:0]        rsp_row_number,
   output logic [15:0]        rsp_byte_position,
   output logic               rsp_row_end
);

   logic         rsp_valid_ff;
   pbd_word_type rsp_word_ff;
   logic [15:0]  rsp_pos_ff;
   logic [15:0]  pos_ff, pos_in;
   logic [16:0]  pos_sum;

   assign pop     = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign pos_sum = {1'b0, pos_ff} + {9'd0, pop_word.repeat_count};

   always_comb begin
      pos_in = pos_ff;
      if (pop) begin
         if (pop_word.row_end) begin
            pos_in = 16'd0;
         end else if (pos_sum[16]) begin
            pos_in = 16'hFFFF;
         end else begin
            pos_in = pos_sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff <= 16'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= pop_word;
         rsp_pos_ff  <= pos_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_byte    = rsp_word_ff.pixel_byte;
   assign rsp_repeat_count  = rsp_word_ff.repeat_count;
   assign rsp_row_number    = rsp_word_ff.row_number;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_row_end       = rsp_word_ff.row_end;

   // Loading a row-closing word returns the position to zero
   assert property (@(posedge clock) disable iff (reset || restart)
      (pop && pop_word.row_end) |=> pos_ff == 16'd0)
      else $error("position not cleared at row end");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: hdl/packbits_mono_bitmap_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the PackBits monochrome bitmap decoder.
// Instantiates pbd_front, pbd_queue and pbd_back; depends on pbd_pkg.
//
// Takes one stream byte per cycle on the req_ channel and returns decoded
// words on the rsp_ channel: pixel byte, repeat count, row number, byte
// position within the row (saturating) and a row-end flag. In compressed
// mode each row opens with a byte count followed by PackBits packets; the
// count byte and packet headers give no word, each literal byte gives a
// word with repeat 1 and each run gives one word with repeat 2 to 129. In
// raw mode every byte is a word, rows padded to 16-bit boundaries. Bytes
// beyond the last row are consumed and dropped. Throughput is one byte per
// cycle while req_ready is high: the front end's phase machine pushes each
// data byte's word in the cycle it takes the byte, and a two-entry word
// queue plus the result register let the front keep accepting while a
// result waits downstream. A data byte's word passes through the queue and
// then the result register on its way to rsp_. req_ready falls only when
// the queue holds two words, i.e. after the result side has stalled.
// Write the csr_ registers only while the block is idle: any write to a
// valid index restarts decoding at row zero, awaiting a row count.
module packbits_mono_bitmap_decoder
   import pbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   // Decoded words
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_pixel_byte,
   output logic [7:0]       rsp_repeat_count,
   output logic [11:0]      rsp_row_number,
   output logic [15:0]      rsp_byte_position,
   output logic             rsp_row_end,
   // Configuration writes
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   pbd_queue_status_type q_status;
   pbd_word_type         push_word;
   pbd_word_type         pop_word;
   logic                 push_valid;
   logic                 pop;
   logic                 restart;

   // Classify bytes and build words
   pbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .restart       (restart),
      .q_status      (q_status),
      .push_valid    (push_valid),
      .push_word     (push_word)
   );

   // Hold words between the two halves
   pbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .pop_word   (pop_word),
      .status     (q_status)
   );

   // Track position and drive the result register
   pbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .restart           (restart),
      .q_status          (q_status),
      .pop_word          (pop_word),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_byte    (rsp_pixel_byte),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_row_number    (rsp_row_number),
      .rsp_byte_position (rsp_byte_position),
      .rsp_row_end       (rsp_row_end)
   );

endmodule
`default_nettype wire

// File: bench/packbits_mono_bitmap_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the PackBits monochrome bitmap decoder: a word predictor
// with its scoreboard, and the top module that drives bytes and register writes.
// Depends on pbd_pkg and the packbits_mono_bitmap_decoder RTL only.
package pbd_bench_pkg;
   import pbd_pkg::*;

   typedef enum logic [1:0] {
      AWAIT_COUNT,
      AWAIT_HEADER,
      IN_LITERAL,
      AWAIT_RUN_BYTE
   } scan_state_type;

   typedef struct packed {
      logic [7:0]  pixel_byte;
      logic [7:0]  repeat_count;
      logic [11:0] row_number;
      logic [15:0] byte_position;
      logic        row_end;
   } decoded_word_type;

   class row_word_tracker;
      decoded_word_type pending_words[$];
      int unsigned   mismatches;
      int unsigned   words_checked;
      int unsigned   rows_closed;

      logic          packed_rows;
      logic [12:0]   width_px;
      logic [12:0]   height_px;

      scan_state_type scan;
      logic [7:0]    count_byte;
      logic [7:0]    lit_left;
      logic [7:0]    run_rep;
      logic [15:0]   used;
      logic [15:0]   pos;
      logic [12:0]   row;

      function new();
         packed_rows = 1'b1;
         width_px    = 13'd1;
         height_px   = 13'd1;
         rewind();
      endfunction

      function void rewind();
         scan       = AWAIT_COUNT;
         count_byte = '0;
         lit_left   = '0;
         run_rep    = '0;
         used       = '0;
         pos        = '0;
         row        = '0;
      endfunction

      // A write to a real register restarts decoding; the spare index does nothing
      function void apply_setting(logic [1:0] idx, logic [12:0] val);
         case (idx)
            CSR_COMPRESSED_MODE: packed_rows = val[0];
            CSR_WIDTH_PIXELS:    width_px = val;
            CSR_HEIGHT_ROWS:     height_px = val;
            default:             return;
         endcase
         rewind();
      endfunction

      function int unsigned raw_stride();
         return ((int'(width_px) + 15) / 16) * 2;
      endfunction

      function void close_row();
         row  = row + 13'd1;
         scan = AWAIT_COUNT;
      endfunction

      function void advance_pos(int unsigned n);
         int unsigned sum;
         sum = int'(pos) + n;
         pos = (sum > 65535) ? 16'hFFFF : 16'(sum);
      endfunction

      function void post_word(logic [7:0] b, logic [7:0] rep, logic [15:0] at, logic last);
         decoded_word_type w;
         w = '{pixel_byte: b, repeat_count: rep, row_number: row[11:0],
               byte_position: at, row_end: last};
         pending_words.insert(pending_words.size(), w);
      endfunction

      // Returns 1 when the byte moved the decoder, 0 when it was dropped
      function bit take_byte(logic [7:0] b);
         int unsigned stride;
         logic        last;
         logic [12:0] cap;
         cap = (height_px > MAX_ROWS) ? MAX_ROWS : height_px;
         if (row >= cap) return 1'b0;
         if (!packed_rows) begin
            stride = raw_stride();
            if (stride == 0) return 1'b0;
            last = (int'(used) + 1 >= stride);
            post_word(b, 8'd1, used, last);
            used = used + 16'd1;
            if (last) begin
               used = '0;
               close_row();
            end
            return 1'b1;
         end
         case (scan)
            AWAIT_COUNT: begin
               count_byte = b;
               used       = '0;
               pos        = '0;
               if (b == 8'd0) close_row();
               else scan = AWAIT_HEADER;
            end
            AWAIT_HEADER: begin
               used = used + 16'd1;
               if (b < 8'd128) begin
                  lit_left = b + 8'd1;
                  scan     = IN_LITERAL;
               end else begin
                  run_rep = 8'(257 - int'(b));
                  scan    = AWAIT_RUN_BYTE;
               end
            end
            IN_LITERAL: begin
               used     = used + 16'd1;
               lit_left = lit_left - 8'd1;
               last     = (lit_left == 8'd0) && (used >= {8'd0, count_byte});
               post_word(b, 8'd1, pos, last);
               advance_pos(1);
               if (lit_left == 8'd0) begin
                  if (last) close_row();
                  else scan = AWAIT_HEADER;
               end
            end
            default: begin
               used = used + 16'd1;
               last = (used >= {8'd0, count_byte});
               post_word(b, run_rep, pos, last);
               advance_pos(int'(run_rep));
               if (last) close_row();
               else scan = AWAIT_HEADER;
            end
         endcase
         return 1'b1;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_word(decoded_word_type got);
         decoded_word_type want;
         if (pending_words.size() == 0) begin
            $error("word with nothing expected: pixel_byte %0d row_number %0d",
                   got.pixel_byte, got.row_number);
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (got.row_end) rows_closed++;
         compare_field("pixel_byte", want.pixel_byte, got.pixel_byte);
         compare_field("repeat_count", want.repeat_count, got.repeat_count);
         compare_field("row_number", want.row_number, got.row_number);
         compare_field("byte_position", want.byte_position, got.byte_position);
         compare_field("row_end", want.row_end, got.row_end);
      endfunction
   endclass
endpackage

module packbits_mono_bitmap_decoder_tb;
   import pbd_pkg::*;
   import pbd_bench_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned BYTE_TARGET   = 1450;
   localparam int unsigned IDLE_PERCENT  = 21;
   // Index with no register behind it
   localparam logic [1:0]  CSR_SPARE     = 2'd3;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_pixel_byte;
   logic [7:0]  rsp_repeat_count;
   logic [11:0] rsp_row_number;
   logic [15:0] rsp_byte_position;
   logic        rsp_row_end;
   logic        csr_write     = 1'b0;
   logic [1:0]  csr_index     = CSR_COMPRESSED_MODE;
   logic [12:0] csr_wdata     = 13'd0;

   row_word_tracker tracker;
   // High while neither side is allowed to idle
   bit          steady         = 1'b0;
   int unsigned bytes_taken    = 0;
   int unsigned settings_used  = 0;
   int unsigned cycle_count    = 0;

   packbits_mono_bitmap_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_byte    (rsp_pixel_byte),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_row_number    (rsp_row_number),
      .rsp_byte_position (rsp_byte_position),
      .rsp_row_end       (rsp_row_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abandon the run once the cycle count reaches CYCLE_LIMIT
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: drop ready at random, except in the steady stretch
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Check every word as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_word('{pixel_byte: rsp_pixel_byte, repeat_count: rsp_repeat_count,
                              row_number: rsp_row_number, byte_position: rsp_byte_position,
                              row_end: rsp_row_end});
   end

   // Offer one byte, idling first at random; hold it until the block takes it.
   // Returns at the falling edge after the handshake with valid still high, so the
   // next call either idles or offers the next byte with a single update.
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (tracker.take_byte(b)) bytes_taken++;
      @(negedge clock);
   endtask

   // Hold the input side until every predicted word has come back
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending_words.size() != 0);
   endtask

   // Write one register once the block is idle; give a header-only byte time to settle
   task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
      drain_words();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      tracker.apply_setting(idx, val);
   endtask

   // One well-formed compressed row: count byte, then packets until the count is used
   task automatic send_packed_row();
      int unsigned target;
      int unsigned spent;
      logic [7:0]  hdr;
      case ($urandom_range(19))
         0:       target = 0;
         1:       target = $urandom_range(128, 255);
         default: target = $urandom_range(1, 24);
      endcase
      send_byte(8'(target));
      spent = 0;
      while (spent < target) begin
         if ($urandom_range(1) == 1) begin
            hdr = ($urandom_range(24) == 0) ? 8'($urandom_range(8, 127))
                                            : 8'($urandom_range(0, 7));
            send_byte(hdr);
            repeat (int'(hdr) + 1) send_byte(8'($urandom_range(255)));
            spent += int'(hdr) + 2;
         end else begin
            send_byte(8'($urandom_range(128, 255)));
            send_byte(8'($urandom_range(255)));
            spent += 2;
         end
      end
   endtask

   // Pick a register setting, write it and stream a few rows under it
   task automatic run_setting();
      logic        compressed;
      logic [12:0] width_px;
      logic [12:0] height_px;
      int unsigned rows;
      int unsigned stride;
      compressed = ($urandom_range(3) != 0);
      case ($urandom_range(9))
         0:       width_px = 13'd1;
         1:       width_px = 13'd4096;
         2:       width_px = 13'd8191;
         3:       width_px = 13'd0;
         default: width_px = 13'($urandom_range(1, 160));
      endcase
      case ($urandom_range(11))
         0:       height_px = 13'd0;
         1:       height_px = 13'd4096;
         2:       height_px = 13'd8191;
         3:       height_px = 13'd1;
         default: height_px = 13'($urandom_range(2, 8));
      endcase
      write_reg(CSR_COMPRESSED_MODE, {12'd0, compressed});
      write_reg(CSR_WIDTH_PIXELS, width_px);
      write_reg(CSR_HEIGHT_ROWS, height_px);
      if ($urandom_range(5) == 0) write_reg(CSR_SPARE, 13'($urandom_range(8191)));
      settings_used++;
      rows = $urandom_range(1, 8);
      if (height_px != 13'd0 && int'(height_px) < rows) rows = height_px;
      if (compressed) begin
         for (int r = 0; r < rows; r++) begin
            // Now and then a broken row: a few loose bytes knock the framing off
            if ($urandom_range(11) == 0) repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(255)));
            else send_packed_row();
            if ($urandom_range(7) == 0) drain_words();
         end
      end else begin
         stride = tracker.raw_stride();
         if (stride > 64) rows = 1;
         for (int r = 0; r < rows; r++) begin
            repeat (stride) send_byte(8'($urandom_range(255)));
            if ($urandom_range(7) == 0) drain_words();
         end
      end
      // Trailing bytes land past the last row, or start a row the height cuts off
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      tracker = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Compressed, four rows: an empty row, a literal then a run that overshoots
      // the count, the longest run, and a literal that outlives its count.
      // The last two bytes fall past the final row and must be dropped.
      write_reg(CSR_HEIGHT_ROWS, 13'd4);
      write_reg(CSR_WIDTH_PIXELS, 13'd8);
      settings_used++;
      send_byte(8'h00);
      send_byte(8'h03); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h02); send_byte(8'h80); send_byte(8'hA5);
      send_byte(8'h01); send_byte(8'h01); send_byte(8'h5A); send_byte(8'h80);
      send_byte(8'h12); send_byte(8'h34);

      // Raw, narrowest width: two-byte rows, two of them, then one dropped byte
      write_reg(CSR_COMPRESSED_MODE, 13'd0);
      write_reg(CSR_WIDTH_PIXELS, 13'd1);
      write_reg(CSR_HEIGHT_ROWS, 13'd2);
      settings_used++;
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h0F); send_byte(8'hF0); send_byte(8'h77);

      // Raw with zero width: rows hold nothing, every byte is dropped
      write_reg(CSR_WIDTH_PIXELS, 13'd0);
      settings_used++;
      send_byte(8'hAA); send_byte(8'h55);

      // Zero height: nothing to decode at all
      write_reg(CSR_COMPRESSED_MODE, 13'd1);
      write_reg(CSR_HEIGHT_ROWS, 13'd0);
      settings_used++;
      send_byte(8'h01); send_byte(8'h81);

      // Random settings; a run of them in the middle with no idling on either side
      while (bytes_taken < BYTE_TARGET) begin
         steady = (settings_used >= 10 && settings_used < 16);
         run_setting();
      end
      steady = 1'b0;

      drain_words();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Decoded %0d bytes over %0d register settings in both modes;", bytes_taken,
               settings_used);
      $display("%0d words compared, %0d rows closed.", tracker.words_checked,
               tracker.rows_closed);
      if (tracker.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
